### design/rwc_pkg.sv
// Shared constants and types for the ray, wall and circle nearest-hit caster.
`timescale 1ns / 1ps
package rwc_pkg;

    localparam int MAX_CIRCLES = 64;
    localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

    localparam int POS_W = 16;
    localparam int DIR_W = 16;
    localparam int RAD_W = 13;
    localparam int SLOT_W = 6;
    localparam int DIST_W = 17;
    localparam int FRAC_W = 14;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [POS_W-1:0] ROOM_RESET = 16'd10240;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOM_HEIGHT = 2'd1;

    localparam int DIV_NUM_W = POS_W + FRAC_W;
    localparam int DIV_DEN_W = DIR_W;
    localparam int SQ_IN_W = 38;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    typedef struct packed {
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [RAD_W-1:0] r;
    } circle_t;

    localparam int ENTRY_W = $bits(circle_t);

endpackage

### design/rwc_item_if.sv
// Channel interfaces for input items, results and configuration writes.
`timescale 1ns / 1ps
interface rwc_item_if import rwc_pkg::*; ();
    logic valid;
    logic ready;
    logic op;
    logic [SLOT_W-1:0] entry_index;
    logic [POS_W-1:0] entry_center_x;
    logic [POS_W-1:0] entry_center_y;
    logic [RAD_W-1:0] entry_radius;
    logic entry_valid;
    logic [POS_W-1:0] origin_x;
    logic [POS_W-1:0] origin_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;

    modport source (output valid, op, entry_index, entry_center_x, entry_center_y,
                    entry_radius, entry_valid, origin_x, origin_y, dir_x, dir_y,
                    input ready);
    modport sink (input valid, op, entry_index, entry_center_x, entry_center_y,
                  entry_radius, entry_valid, origin_x, origin_y, dir_x, dir_y,
                  output ready);
endinterface

interface rwc_result_if import rwc_pkg::*; ();
    logic valid;
    logic ready;
    logic hit;
    logic [DIST_W-1:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink (input valid, hit, distance, output ready);
endinterface

interface rwc_cfg_if import rwc_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [POS_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/rwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/rwc_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module rwc_div import rwc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(DIV_NUM_W + 1);

    logic busy_reg;
    logic done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0] rem_sh;
    logic ge;

    assign rem_sh = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
    assign ge = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= DCNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

### design/rwc_sqrt.sv
// Integer square root that resolves one root bit per cycle.
`timescale 1ns / 1ps
module rwc_sqrt import rwc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic                busy,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int SCNT_W = $clog2(SQ_OUT_W + 1);

    logic busy_reg;
    logic done_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic [SQ_IN_W-1:0] rem_reg;
    logic [SQ_IN_W-1:0] root_reg;
    logic [SQ_IN_W-1:0] bit_reg;
    logic [SQ_IN_W-1:0] trial;
    logic ge;

    assign trial = root_reg + bit_reg;
    assign ge = rem_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= SCNT_W'(SQ_OUT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            root_reg <= '0;
            bit_reg <= {2'b01, {(SQ_IN_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg[SQ_OUT_W-1:0];

endmodule

### design/ray_wall_circle_nearest_hit.sv
// Top level of the ray caster: circle table, cast sequencer and result register.
`timescale 1ns / 1ps
// A write item updates one circle table entry. A cast visits the four walls,
// each with at most one pass of a 30-step divider, and then every table entry:
// an invalid entry is skipped, a valid one goes through the table read, the
// multiplier steps and at most one pass of a 19-step square root; the result
// then waits in an output register and the block takes the next item.
// The table valid bits clear at reset, so no clearing pass is needed.
module ray_wall_circle_nearest_hit import rwc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    rwc_item_if.sink           item,
    rwc_result_if.source       result,
    rwc_cfg_if.sink            cfg
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_W_SET  = 4'd1;
    localparam logic [3:0] ST_W_MUL  = 4'd2;
    localparam logic [3:0] ST_W_CHK  = 4'd3;
    localparam logic [3:0] ST_W_DIV  = 4'd4;
    localparam logic [3:0] ST_C_RD   = 4'd5;
    localparam logic [3:0] ST_C_OC   = 4'd6;
    localparam logic [3:0] ST_C_MUL  = 4'd7;
    localparam logic [3:0] ST_C_SUM  = 4'd8;
    localparam logic [3:0] ST_C_Q    = 4'd9;
    localparam logic [3:0] ST_C_QQ   = 4'd10;
    localparam logic [3:0] ST_C_PERP = 4'd11;
    localparam logic [3:0] ST_C_SQ   = 4'd12;
    localparam logic [3:0] ST_FIN    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [POS_W-1:0] room_w_reg;
    logic [POS_W-1:0] room_h_reg;
    logic [MAX_CIRCLES-1:0] valid_reg;

    logic [POS_W-1:0] ox_reg;
    logic [POS_W-1:0] oy_reg;
    logic signed [DIR_W-1:0] dx_reg;
    logic signed [DIR_W-1:0] dy_reg;
    logic [1:0] wall_reg;
    logic [CNT_W-1:0] idx_reg;
    logic found_reg;
    logic [DIST_W-1:0] best_reg;

    logic [POS_W-1:0] w_num_reg;
    logic [DIR_W-1:0] w_d_reg;
    logic signed [DIR_W:0] w_d2_reg;
    logic [POS_W-1:0] w_o2_reg;
    logic [POS_W-1:0] w_ext_reg;
    logic [2*POS_W-1:0] w_m1_reg;
    logic signed [2*DIR_W+1:0] w_m2_reg;
    logic [2*POS_W-1:0] w_m3_reg;

    logic signed [POS_W:0] ocx_reg;
    logic signed [POS_W:0] ocy_reg;
    logic [RAD_W-1:0] rad_reg;
    logic signed [2*POS_W+1:0] px_reg;
    logic signed [2*POS_W+1:0] py_reg;
    logic signed [2*POS_W+1:0] sx_reg;
    logic signed [2*POS_W+1:0] sy_reg;
    logic [2*RAD_W-1:0] rr_reg;
    logic signed [2*POS_W+2:0] p_reg;
    logic [2*POS_W:0] ssq_reg;
    logic [17:0] q_reg;
    logic [35:0] qq_reg;

    logic res_valid_reg;
    logic res_hit_reg;
    logic [DIST_W-1:0] res_dist_reg;

    logic item_xfer;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic ram_re;
    circle_t wr_entry;
    circle_t rd_entry;
    logic last_idx;

    logic axis;
    logic [POS_W-1:0] s_o;
    logic signed [DIR_W-1:0] s_d;
    logic [POS_W-1:0] s_o2;
    logic signed [DIR_W-1:0] s_d2;
    logic [POS_W-1:0] s_ext;
    logic [POS_W-1:0] s_wpos;
    logic signed [POS_W:0] s_num_raw;
    logic signed [POS_W:0] s_num;
    logic signed [DIR_W:0] s_d_abs;
    logic signed [DIR_W:0] s_d2_adj;
    logic s_skip;

    logic signed [2*POS_W+2:0] cross_sum;
    logic cross_ok;

    logic signed [2*POS_W+5:0] perp;
    logic perp_skip;
    logic [SQ_IN_W-1:0] sq_in;
    logic signed [19:0] c_t;

    logic div_start;
    logic div_busy;
    logic div_done;
    logic [DIV_NUM_W-1:0] div_q;
    logic sq_start;
    logic sq_busy;
    logic sq_done;
    logic [SQ_OUT_W-1:0] sq_root;

    logic upd_en;
    logic [DIST_W-1:0] upd_t;
    logic res_load;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_xfer = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign wr_idx = item.entry_index[IDX_W-1:0];
    assign wr_en = item_xfer && (item.op == OP_WRITE)
                   && (32'(item.entry_index) < MAX_CIRCLES);
    assign wr_entry = '{cx: item.entry_center_x, cy: item.entry_center_y,
                        r: item.entry_radius};
    assign rd_idx = idx_reg[IDX_W-1:0];
    assign ram_re = (state_reg == ST_C_RD) && valid_reg[rd_idx];
    assign last_idx = (idx_reg == CNT_W'(MAX_CIRCLES - 1));

    rwc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_CIRCLES)
    ) u_table (
        .clk(clk),
        .we(wr_en),
        .waddr(wr_idx),
        .wdata(wr_entry),
        .re(ram_re),
        .raddr(rd_idx),
        .rdata(rd_entry)
    );

    rwc_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend({w_num_reg, {FRAC_W{1'b0}}}),
        .divisor(w_d_reg),
        .busy(div_busy),
        .done(div_done),
        .quotient(div_q)
    );

    rwc_sqrt u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(sq_start),
        .radicand(sq_in),
        .busy(sq_busy),
        .done(sq_done),
        .root(sq_root)
    );

    always_comb
    begin
        axis = wall_reg[1];
        s_o = axis ? oy_reg : ox_reg;
        s_d = axis ? dy_reg : dx_reg;
        s_o2 = axis ? ox_reg : oy_reg;
        s_d2 = axis ? dx_reg : dy_reg;
        s_ext = axis ? room_w_reg : room_h_reg;
        s_wpos = wall_reg[0] ? (axis ? room_h_reg : room_w_reg) : '0;
        s_num_raw = $signed({1'b0, s_wpos}) - $signed({1'b0, s_o});
        if (s_d < 0)
        begin
            s_num = -s_num_raw;
            s_d_abs = -$signed({s_d[DIR_W-1], s_d});
            s_d2_adj = -$signed({s_d2[DIR_W-1], s_d2});
        end
        else
        begin
            s_num = s_num_raw;
            s_d_abs = $signed({s_d[DIR_W-1], s_d});
            s_d2_adj = $signed({s_d2[DIR_W-1], s_d2});
        end
        s_skip = (s_d == 0) || (s_num <= 0);
    end

    assign cross_sum = $signed({3'b000, w_m1_reg})
                       + $signed({w_m2_reg[2*DIR_W+1], w_m2_reg});
    assign cross_ok = !cross_sum[2*POS_W+2]
                      && ($unsigned(cross_sum) <= {3'b000, w_m3_reg});

    assign perp = $signed({5'b0, ssq_reg}) - $signed({2'b0, qq_reg});
    assign perp_skip = perp > $signed({12'b0, rr_reg});
    assign sq_in = SQ_IN_W'($unsigned($signed({12'b0, rr_reg}) - perp));
    assign c_t = $signed({2'b00, q_reg}) - $signed({1'b0, sq_root});

    assign div_start = (state_reg == ST_W_CHK) && cross_ok;
    assign sq_start = (state_reg == ST_C_PERP) && !perp_skip;

    always_comb
    begin
        upd_en = 1'b0;
        upd_t = '0;
        if ((state_reg == ST_W_DIV) && div_done)
        begin
            upd_en = 1'b1;
            upd_t = (|div_q[DIV_NUM_W-1:DIST_W]) ? DIST_MAX : div_q[DIST_W-1:0];
        end
        else if ((state_reg == ST_C_SQ) && sq_done && (c_t > 0))
        begin
            upd_en = 1'b1;
            upd_t = (|c_t[19:DIST_W]) ? DIST_MAX : c_t[DIST_W-1:0];
        end
    end

    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && (item.op == OP_CAST))
                begin
                    state_next = ST_W_SET;
                end
            end
            ST_W_SET:
            begin
                if (s_skip)
                begin
                    state_next = (wall_reg == 2'd3) ? ST_C_RD : ST_W_SET;
                end
                else
                begin
                    state_next = ST_W_MUL;
                end
            end
            ST_W_MUL:
            begin
                state_next = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (cross_ok)
                begin
                    state_next = ST_W_DIV;
                end
                else
                begin
                    state_next = (wall_reg == 2'd3) ? ST_C_RD : ST_W_SET;
                end
            end
            ST_W_DIV:
            begin
                if (div_done)
                begin
                    state_next = (wall_reg == 2'd3) ? ST_C_RD : ST_W_SET;
                end
            end
            ST_C_RD:
            begin
                if (valid_reg[rd_idx])
                begin
                    state_next = ST_C_OC;
                end
                else
                begin
                    state_next = last_idx ? ST_FIN : ST_C_RD;
                end
            end
            ST_C_OC:
            begin
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                state_next = ST_C_SUM;
            end
            ST_C_SUM:
            begin
                state_next = ST_C_Q;
            end
            ST_C_Q:
            begin
                if ((p_reg <= 0))
                begin
                    state_next = last_idx ? ST_FIN : ST_C_RD;
                end
                else
                begin
                    state_next = ST_C_QQ;
                end
            end
            ST_C_QQ:
            begin
                state_next = ST_C_PERP;
            end
            ST_C_PERP:
            begin
                if (perp_skip)
                begin
                    state_next = last_idx ? ST_FIN : ST_C_RD;
                end
                else
                begin
                    state_next = ST_C_SQ;
                end
            end
            ST_C_SQ:
            begin
                if (sq_done)
                begin
                    state_next = last_idx ? ST_FIN : ST_C_RD;
                end
            end
            ST_FIN:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            room_w_reg <= ROOM_RESET;
            room_h_reg <= ROOM_RESET;
            valid_reg <= '0;
            wall_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ROOM_WIDTH)
                begin
                    room_w_reg <= cfg.data;
                end
                else if (cfg.index == CFG_ROOM_HEIGHT)
                begin
                    room_h_reg <= cfg.data;
                end
            end
            if (wr_en)
            begin
                valid_reg[wr_idx] <= item.entry_valid;
            end
            if (item_xfer && (item.op == OP_CAST))
            begin
                wall_reg <= '0;
                idx_reg <= '0;
                found_reg <= 1'b0;
                best_reg <= '0;
            end
            if (((state_reg == ST_W_SET) && s_skip)
                || ((state_reg == ST_W_CHK) && !cross_ok)
                || ((state_reg == ST_W_DIV) && div_done))
            begin
                wall_reg <= wall_reg + 1'b1;
            end
            if ((state_next == ST_C_RD) && (state_reg != ST_C_RD)
                && (state_reg >= ST_C_RD))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if ((state_reg == ST_C_RD) && (state_next == ST_C_RD))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (upd_en && (!found_reg || (upd_t < best_reg)))
            begin
                best_reg <= upd_t;
                found_reg <= 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer && (item.op == OP_CAST))
        begin
            ox_reg <= item.origin_x;
            oy_reg <= item.origin_y;
            dx_reg <= item.dir_x;
            dy_reg <= item.dir_y;
        end
        if (state_reg == ST_W_SET)
        begin
            w_num_reg <= s_num[POS_W-1:0];
            w_d_reg <= s_d_abs[DIR_W-1:0];
            w_d2_reg <= s_d2_adj;
            w_o2_reg <= s_o2;
            w_ext_reg <= s_ext;
        end
        if (state_reg == ST_W_MUL)
        begin
            w_m1_reg <= w_o2_reg * w_d_reg;
            w_m2_reg <= $signed({1'b0, w_num_reg}) * w_d2_reg;
            w_m3_reg <= w_ext_reg * w_d_reg;
        end
        if (state_reg == ST_C_OC)
        begin
            ocx_reg <= $signed({1'b0, rd_entry.cx}) - $signed({1'b0, ox_reg});
            ocy_reg <= $signed({1'b0, rd_entry.cy}) - $signed({1'b0, oy_reg});
            rad_reg <= rd_entry.r;
        end
        if (state_reg == ST_C_MUL)
        begin
            px_reg <= ocx_reg * $signed({dx_reg[DIR_W-1], dx_reg});
            py_reg <= ocy_reg * $signed({dy_reg[DIR_W-1], dy_reg});
            sx_reg <= ocx_reg * ocx_reg;
            sy_reg <= ocy_reg * ocy_reg;
            rr_reg <= rad_reg * rad_reg;
        end
        if (state_reg == ST_C_SUM)
        begin
            p_reg <= $signed({px_reg[2*POS_W+1], px_reg})
                     + $signed({py_reg[2*POS_W+1], py_reg});
            ssq_reg <= {1'b0, sx_reg[2*POS_W-1:0]} + {1'b0, sy_reg[2*POS_W-1:0]};
        end
        if (state_reg == ST_C_Q)
        begin
            q_reg <= p_reg[2*POS_W-1:FRAC_W];
        end
        if (state_reg == ST_C_QQ)
        begin
            qq_reg <= q_reg * q_reg;
        end
        if (res_load)
        begin
            res_hit_reg <= found_reg;
            res_dist_reg <= found_reg ? best_reg : '0;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.hit = res_hit_reg;
    assign result.distance = res_dist_reg;

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_busy && sq_busy))
        else $error("Divider and square root unit busy together.");

    a_valid_written: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (valid_reg[$past(wr_idx)] == $past(item.entry_valid)))
        else $error("Table valid bit does not follow the write transfer.");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("Result raised outside the finishing step.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_hit_reg) |-> (res_dist_reg == '0))
        else $error("Miss reported with a nonzero distance.");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the ray caster: random and directed items against a predictor.
`timescale 1ns / 1ps
module tb_top import rwc_pkg::*; ();

    typedef struct {
        logic              op;
        logic [SLOT_W-1:0] entry_index;
        logic [POS_W-1:0]  entry_center_x;
        logic [POS_W-1:0]  entry_center_y;
        logic [RAD_W-1:0]  entry_radius;
        logic              entry_valid;
        logic [POS_W-1:0]  origin_x;
        logic [POS_W-1:0]  origin_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
    } ray_item_t;

    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } hit_t;

    class hit_scoreboard;
        circle_t           table_q [MAX_CIRCLES];
        logic              live [MAX_CIRCLES];
        logic [POS_W-1:0]  room_w;
        logic [POS_W-1:0]  room_h;
        hit_t              pending_hits [$];
        int                errors;

        function void clear();
            for (int i = 0; i < MAX_CIRCLES; i++)
            begin
                table_q[i] = '0;
                live[i] = 1'b0;
            end
            room_w = ROOM_RESET;
            room_h = ROOM_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
            if (idx == CFG_ROOM_WIDTH) room_w = val;
            else if (idx == CFG_ROOM_HEIGHT) room_h = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void try_wall(longint w, longint o, longint d, longint o2, longint d2,
                               longint ext2, ref longint best, ref bit found);
            longint num;
            longint cross_sum;
            longint t;
            num = w - o;
            if (d == 0) return;
            if (d < 0)
            begin
                num = -num;
                d = -d;
                d2 = -d2;
            end
            if (num <= 0) return;
            cross_sum = o2 * d + num * d2;
            if (cross_sum < 0 || cross_sum > ext2 * d) return;
            t = (num * 16384) / d;
            if (t > DIST_MAX) t = DIST_MAX;
            if (!found || t < best)
            begin
                best = t;
                found = 1;
            end
        endfunction

        function void note_input(ray_item_t it);
            longint ox, oy, dx, dy, w, h, best, ocx, ocy, p, q, perp, r2, t;
            bit found;
            hit_t e;
            if (it.op == OP_WRITE)
            begin
                table_q[it.entry_index] = '{it.entry_center_x, it.entry_center_y,
                                            it.entry_radius};
                live[it.entry_index] = it.entry_valid;
                return;
            end
            ox = it.origin_x;
            oy = it.origin_y;
            dx = it.dir_x;
            dy = it.dir_y;
            w = room_w;
            h = room_h;
            best = 0;
            found = 0;
            try_wall(0, ox, dx, oy, dy, h, best, found);
            try_wall(w, ox, dx, oy, dy, h, best, found);
            try_wall(0, oy, dy, ox, dx, w, best, found);
            try_wall(h, oy, dy, ox, dx, w, best, found);
            for (int i = 0; i < MAX_CIRCLES; i++)
            begin
                if (!live[i]) continue;
                ocx = longint'(table_q[i].cx) - ox;
                ocy = longint'(table_q[i].cy) - oy;
                p = ocx * dx + ocy * dy;
                if (p <= 0) continue;
                q = p >>> 14;
                perp = ocx * ocx + ocy * ocy - q * q;
                r2 = longint'(table_q[i].r) * longint'(table_q[i].r);
                if (perp > r2) continue;
                t = q - longint'(int_sqrt(r2 - perp));
                if (t <= 0) continue;
                if (t > DIST_MAX) t = DIST_MAX;
                if (!found || t < best)
                begin
                    best = t;
                    found = 1;
                end
            end
            e.hit = found;
            e.distance = found ? best[DIST_W-1:0] : '0;
            pending_hits = {pending_hits, e};
        endfunction

        function void check_result(logic hit, logic [DIST_W-1:0] distance);
            hit_t e;
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result hit=%0d distance=%0d", hit, distance);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (hit !== e.hit)
            begin
                $error("hit expected %0d actual %0d", e.hit, hit);
                errors++;
            end
            if (distance !== e.distance)
            begin
                $error("distance expected %0d actual %0d", e.distance, distance);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rwc_item_if   item ();
    rwc_result_if result ();
    rwc_cfg_if    cfg ();

    hit_scoreboard sb;
    bit  hold_req;
    int  hold_left;
    bit  calm;

    ray_wall_circle_nearest_hit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item.valid && item.ready)
                sb.note_input('{item.op, item.entry_index, item.entry_center_x,
                                item.entry_center_y, item.entry_radius, item.entry_valid,
                                item.origin_x, item.origin_y, item.dir_x, item.dir_y});
            if (result.valid && result.ready)
                sb.check_result(result.hit, result.distance);
            if (cfg.valid && cfg.ready)
                sb.set_reg(cfg.index, cfg.data);
        end
    end

    // Result side: random back-pressure, always ready while calm, one long hold-off on request.
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (calm)
                result.ready <= 1'b1;
            else
                result.ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    task automatic send_item(ray_item_t it);
        if (!calm && $urandom_range(0, 99) < 26)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.op <= it.op;
        item.entry_index <= it.entry_index;
        item.entry_center_x <= it.entry_center_x;
        item.entry_center_y <= it.entry_center_y;
        item.entry_radius <= it.entry_radius;
        item.entry_valid <= it.entry_valid;
        item.origin_x <= it.origin_x;
        item.origin_y <= it.origin_y;
        item.dir_x <= it.dir_x;
        item.dir_y <= it.dir_y;
        item.valid <= 1'b1;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_hits.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
        cfg.index <= idx;
        cfg.data <= val;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic ray_item_t noise();
        ray_item_t it;
        it.op = 1'($urandom_range(0, 1));
        it.entry_index = SLOT_W'($urandom);
        it.entry_center_x = POS_W'($urandom);
        it.entry_center_y = POS_W'($urandom);
        it.entry_radius = RAD_W'($urandom);
        it.entry_valid = 1'($urandom);
        it.origin_x = POS_W'($urandom);
        it.origin_y = POS_W'($urandom);
        it.dir_x = DIR_W'($urandom);
        it.dir_y = DIR_W'($urandom);
        return it;
    endfunction

    function automatic ray_item_t circle_write(int idx, int cx, int cy, int r, bit v);
        ray_item_t it;
        it = noise();
        it.op = OP_WRITE;
        it.entry_index = SLOT_W'(idx);
        it.entry_center_x = POS_W'(cx);
        it.entry_center_y = POS_W'(cy);
        it.entry_radius = RAD_W'(r);
        it.entry_valid = v;
        return it;
    endfunction

    function automatic ray_item_t ray_cast(int ox, int oy, int dx, int dy);
        ray_item_t it;
        it = noise();
        it.op = OP_CAST;
        it.origin_x = POS_W'(ox);
        it.origin_y = POS_W'(oy);
        it.dir_x = DIR_W'(dx);
        it.dir_y = DIR_W'(dy);
        return it;
    endfunction

    function automatic int near_room(int ext);
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
        return int'($urandom_range(0, ext));
    endfunction

    function automatic ray_item_t random_item();
        int w;
        int h;
        w = int'(sb.room_w);
        h = int'(sb.room_h);
        if ($urandom_range(0, 99) < 40)
            return circle_write(int'($urandom_range(0, 63)), near_room(w), near_room(h),
                                ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191))
                                                             : int'($urandom_range(0, 2000)),
                                $urandom_range(0, 3) == 0);
        return ray_cast(near_room(w), near_room(h),
                        int'($urandom_range(0, 32768)) - 16384,
                        int'($urandom_range(0, 32768)) - 16384);
    endfunction

    initial
    begin
        ray_item_t directed [$];
        sb = new();
        sb.clear();
        hold_req = 0;
        hold_left = 0;
        calm = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.op = OP_WRITE;
        item.entry_index = '0;
        item.entry_center_x = '0;
        item.entry_center_y = '0;
        item.entry_radius = '0;
        item.entry_valid = 1'b0;
        item.origin_x = '0;
        item.origin_y = '0;
        item.dir_x = '0;
        item.dir_y = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_ROOM_WIDTH;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed, ray_cast(5000, 5000, 16384, 0)};
        directed = {directed, circle_write(0, 5000, 5000, 1000, 1)};
        directed = {directed, circle_write(63, 65535, 65535, 8191, 1)};
        directed = {directed, circle_write(5, 8000, 2000, 0, 1)};
        directed = {directed, ray_cast(1000, 5000, 16384, 0)};
        directed = {directed, ray_cast(1000, 5000, -16384, 0)};
        directed = {directed, ray_cast(1000, 5000, 0, 0)};
        directed = {directed, ray_cast(5000, 5000, 16384, 0)};
        directed = {directed, ray_cast(4500, 5000, 16384, 0)};
        directed = {directed, ray_cast(8000, 1000, 0, 16384)};
        directed = {directed, ray_cast(20000, 20000, -16384, -16384)};
        directed = {directed, ray_cast(0, 0, 11585, 11585)};
        directed = {directed, ray_cast(10240, 10240, 0, -16384)};
        directed = {directed, ray_cast(60000, 60000, 16384, 16384)};
        directed = {directed, circle_write(0, 0, 0, 0, 0)};
        directed = {directed, ray_cast(1000, 5000, 16384, 0)};
        directed = {directed, ray_cast(65535, 0, -32768, 32767)};
        foreach (directed[i]) send_item(directed[i]);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_ROOM_WIDTH, 16'hFFFF);
                    write_reg(CFG_ROOM_HEIGHT, 16'hFFFF);
                end
                1:
                begin
                    write_reg(CFG_ROOM_WIDTH, 16'd0);
                    write_reg(CFG_ROOM_HEIGHT, 16'd0);
                end
                2:
                begin
                    write_reg(CFG_ROOM_HEIGHT, 16'($urandom));
                    write_reg(CFG_ROOM_WIDTH, 16'($urandom));
                end
                default:
                begin
                    write_reg(CFG_ROOM_WIDTH, 16'd10240);
                    write_reg(CFG_ROOM_HEIGHT, 16'd20000);
                end
            endcase
            if (phase == 0)
            begin
                // Far wall beyond the distance range saturates the first cast; the second stays in range.
                send_item(ray_cast(0, 100, 1, 0));
                send_item(ray_cast(0, 0, 0, 16384));
            end
            for (int n = 0; n < 475; n++)
            begin
                calm = (phase == 2 && n >= 100 && n < 300);
                if (phase == 1 && n == 200) hold_req = 1;
                send_item(random_item());
            end
            calm = 0;
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
